@@ sv/mrd_pkg.sv @@
// Package with shared types and constants for the mutual reachability block.
package mrd_pkg;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_CORE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_NUM_POINTS = 2'd0;
  localparam logic [1:0] CFG_NUM_DIMS   = 2'd1;
  localparam logic [1:0] CFG_MIN_POINTS = 2'd2;

  // Field widths
  localparam int OUT_W      = 35;
  localparam int CFG_W      = 9;
  localparam int IDX_W      = 8;
  localparam int DIM_IDX_W  = 3;
  localparam int COORD_IN_W = 16;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_RD,
    S_DIF,
    S_MUL,
    S_ACC,
    S_INS_RD,
    S_INS,
    S_CORE_RD,
    S_CORE_WR
  } mrd_state_t;

endpackage

@@ sv/mutual_reachability_distance.sv @@
// Top level: coordinate store, core distance sweep and pair query engine.
// Load without last flag: result in the cycle after the request.
// Query: index reduction steps, then per dim a coordinate pair read, difference, square and accumulate.
// Compute (last load): per point pair a distance as for a query, then a sorted insert into the row
// that compares row entries one by one, plus a core read and write per point; one request at a time.
// Reset (rst_n low, synchronous): registers to 256 / 2 / 5, core results marked invalid.
module mutual_reachability_distance
  import mrd_pkg::*;
#(
  parameter int MAX_POINTS = 256,
  parameter int MAX_DIMS   = 8,
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [IDX_W-1:0]              in_point_index,
  input  logic [DIM_IDX_W-1:0]          in_dim_index,
  input  logic signed [COORD_IN_W-1:0]  in_coord_value,
  input  logic                          in_last_load,
  input  logic [IDX_W-1:0]              in_other_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [OUT_W-1:0]              out_mutual_reach_sq,
  output logic [OUT_W-1:0]              out_core_first_sq,
  output logic [OUT_W-1:0]              out_core_second_sq,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [CFG_W-1:0]              cfg_wdata
);

  localparam int CB    = COORD_BITS;
  localparam int DEPTH = MAX_POINTS * MAX_DIMS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PIW   = $clog2(MAX_POINTS);
  localparam int PW    = $clog2(MAX_POINTS + 1);
  localparam int DCW   = $clog2(MAX_DIMS + 1);
  localparam int SQW   = 2 * CB + 2;
  localparam int DW    = SQW + $clog2(MAX_DIMS);
  localparam int XW    = (PW > CFG_W) ? PW : CFG_W;
  localparam int DXW   = (DCW > 4) ? DCW : 4;
  localparam int XCW   = (CB > COORD_IN_W) ? CB : COORD_IN_W;

  // Memories
  logic [CB-1:0] coord_mem [DEPTH];
  logic [DW-1:0] core_mem  [MAX_POINTS];
  logic [DW-1:0] row_mem   [MAX_POINTS];

  // Registers
  mrd_state_t state_r, state_nxt;
  logic [CFG_W-1:0] num_points_r, num_dims_r, min_points_r;
  logic             cores_valid_r, cores_valid_nxt;
  logic             query_r, query_nxt;
  logic [IDX_W-1:0] qa_r, qa_nxt, qb_r, qb_nxt;
  logic [PW-1:0]    p_r, p_nxt, q_r, q_nxt, r_r, r_nxt;
  logic [PIW-1:0]   pa_r, pa_nxt, pb_r, pb_nxt;
  logic [DCW-1:0]   j_r, j_nxt;
  logic signed [CB:0] diff_r, diff_nxt;
  logic [SQW-1:0]   sq_r, sq_nxt;
  logic [DW-1:0]    acc_r, acc_nxt, v_r, v_nxt;
  logic             out_valid_r, out_valid_nxt, out_status_r, out_status_nxt;
  logic [OUT_W-1:0] out_mr_r, out_mr_nxt, out_ca_r, out_ca_nxt, out_cb_r, out_cb_nxt;

  // Memory read data and controls
  logic [CB-1:0]  rd_a, rd_b;
  logic [DW-1:0]  core_rda, core_rdb, row_rd;
  logic [AW-1:0]  addr_a, addr_b, load_addr;
  logic           coord_we;
  logic [CB-1:0]  coord_wdata;
  logic           core_we, row_we;
  logic [PIW-1:0] row_waddr, row_raddr;
  logic [DW-1:0]  row_wdata;

  // Effective configuration
  logic [PW-1:0]  n_eff, k_eff;
  logic [DCW-1:0] dims_eff;
  logic [XW-1:0]  np_x, mp_x;
  logic [DXW-1:0] nd_x;
  logic [PW-1:0]  r_m1, k_m1;
  logic [DW-1:0]  acc_sum, mr_max;
  logic [CB:0]    mag;
  logic [XCW-1:0] coord_wide;
  logic           load_ok;

  assign in_ready            = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_mutual_reach_sq = out_mr_r;
  assign out_core_first_sq   = out_ca_r;
  assign out_core_second_sq  = out_cb_r;

  // Clamp register values to their working ranges
  always_comb begin
    np_x = XW'(num_points_r);
    mp_x = XW'(min_points_r);
    nd_x = DXW'(num_dims_r);
    if (np_x == '0) begin
      n_eff = PW'(1);
    end else if (np_x > XW'(MAX_POINTS)) begin
      n_eff = PW'(MAX_POINTS);
    end else begin
      n_eff = PW'(np_x);
    end
    if (mp_x == '0) begin
      k_eff = PW'(1);
    end else if (mp_x > XW'(n_eff)) begin
      k_eff = n_eff;
    end else begin
      k_eff = PW'(mp_x);
    end
    if (nd_x == '0) begin
      dims_eff = DCW'(1);
    end else if (nd_x > DXW'(MAX_DIMS)) begin
      dims_eff = DCW'(MAX_DIMS);
    end else begin
      dims_eff = DCW'(nd_x);
    end
  end

  // Datapath helpers
  assign addr_a     = AW'(pa_r) * AW'(MAX_DIMS) + AW'(j_r);
  assign addr_b     = AW'(pb_r) * AW'(MAX_DIMS) + AW'(j_r);
  assign load_addr  = AW'(in_point_index) * AW'(MAX_DIMS) + AW'(in_dim_index);
  assign load_ok    = (int'(in_point_index) < MAX_POINTS) && (int'(in_dim_index) < MAX_DIMS);
  assign coord_wide = XCW'($unsigned(in_coord_value));
  assign acc_sum    = acc_r + DW'(sq_r);
  assign mag        = diff_r[CB] ? $unsigned(-diff_r) : $unsigned(diff_r);
  assign r_m1       = r_r - PW'(1);
  assign k_m1       = k_eff - PW'(1);

  always_comb begin
    mr_max = acc_sum;
    if (core_rda > mr_max) mr_max = core_rda;
    if (core_rdb > mr_max) mr_max = core_rdb;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= CFG_W'(256);
      num_dims_r   <= CFG_W'(2);
      min_points_r <= CFG_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_POINTS: num_points_r <= cfg_wdata;
        CFG_NUM_DIMS:   num_dims_r   <= CFG_W'(cfg_wdata[3:0]);
        CFG_MIN_POINTS: min_points_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Coordinate store: one write port, two read ports
  always_ff @(posedge clk) begin
    if (coord_we) coord_mem[load_addr] <= coord_wdata;
    rd_a <= coord_mem[addr_a];
    rd_b <= coord_mem[addr_b];
  end

  // Core distance store
  always_ff @(posedge clk) begin
    if (core_we) core_mem[pa_r] <= row_rd;
    core_rda <= core_mem[pa_r];
    core_rdb <= core_mem[pb_r];
  end

  // Row scratch holding the smallest distances of the current row, sorted
  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    row_rd <= row_mem[row_raddr];
  end

  // Sequencer state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cores_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cores_valid_r <= cores_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    query_r      <= query_nxt;
    qa_r         <= qa_nxt;
    qb_r         <= qb_nxt;
    p_r          <= p_nxt;
    q_r          <= q_nxt;
    r_r          <= r_nxt;
    pa_r         <= pa_nxt;
    pb_r         <= pb_nxt;
    j_r          <= j_nxt;
    diff_r       <= diff_nxt;
    sq_r         <= sq_nxt;
    acc_r        <= acc_nxt;
    v_r          <= v_nxt;
    out_status_r <= out_status_nxt;
    out_mr_r     <= out_mr_nxt;
    out_ca_r     <= out_ca_nxt;
    out_cb_r     <= out_cb_nxt;
  end

  // Next state and outputs
  always_comb begin
    state_nxt       = state_r;
    cores_valid_nxt = cores_valid_r;
    query_nxt       = query_r;
    qa_nxt          = qa_r;
    qb_nxt          = qb_r;
    p_nxt           = p_r;
    q_nxt           = q_r;
    r_nxt           = r_r;
    pa_nxt          = pa_r;
    pb_nxt          = pb_r;
    j_nxt           = j_r;
    diff_nxt        = diff_r;
    sq_nxt          = sq_r;
    acc_nxt         = acc_r;
    v_nxt           = v_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_mr_nxt      = out_mr_r;
    out_ca_nxt      = out_ca_r;
    out_cb_nxt      = out_cb_r;
    coord_we        = 1'b0;
    coord_wdata     = coord_wide[CB-1:0];
    core_we         = 1'b0;
    row_we          = 1'b0;
    row_waddr       = r_r[PIW-1:0];
    row_wdata       = v_r;
    row_raddr       = r_m1[PIW-1:0];

    // Drop the result once taken
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          out_status_nxt = STATUS_OK;
          out_mr_nxt     = '0;
          out_ca_nxt     = '0;
          out_cb_nxt     = '0;
          if (in_req_type == REQ_LOAD) begin
            coord_we = load_ok;
            if (in_last_load) begin
              query_nxt = 1'b0;
              p_nxt     = '0;
              q_nxt     = '0;
              pa_nxt    = '0;
              pb_nxt    = '0;
              j_nxt     = '0;
              acc_nxt   = '0;
              state_nxt = S_RD;
            end else begin
              out_valid_nxt = 1'b1;
            end
          end else if (!cores_valid_r) begin
            out_status_nxt = STATUS_NO_CORE;
            out_valid_nxt  = 1'b1;
          end else begin
            query_nxt = 1'b1;
            qa_nxt    = in_point_index;
            qb_nxt    = in_other_index;
            state_nxt = S_MOD;
          end
        end
      end

      // Reduce query indexes below MAX_POINTS, one subtract a cycle
      S_MOD: begin
        if (int'(qa_r) >= MAX_POINTS) begin
          qa_nxt = qa_r - IDX_W'(MAX_POINTS);
        end else if (int'(qb_r) >= MAX_POINTS) begin
          qb_nxt = qb_r - IDX_W'(MAX_POINTS);
        end else begin
          pa_nxt    = PIW'(qa_r);
          pb_nxt    = PIW'(qb_r);
          j_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_RD;
        end
      end

      // Coordinate reads in flight
      S_RD: state_nxt = S_DIF;

      S_DIF: begin
        diff_nxt  = $signed({rd_a[CB-1], rd_a}) - $signed({rd_b[CB-1], rd_b});
        state_nxt = S_MUL;
      end

      S_MUL: begin
        sq_nxt    = SQW'(mag) * SQW'(mag);
        state_nxt = S_ACC;
      end

      // Accumulate one dimension, then finish the distance
      S_ACC: begin
        acc_nxt = acc_sum;
        j_nxt   = j_r + DCW'(1);
        if (j_nxt != dims_eff) begin
          state_nxt = S_RD;
        end else if (query_r) begin
          out_status_nxt = STATUS_OK;
          out_mr_nxt     = OUT_W'(mr_max);
          out_ca_nxt     = OUT_W'(core_rda);
          out_cb_nxt     = OUT_W'(core_rdb);
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          v_nxt     = acc_sum;
          r_nxt     = (q_r < k_eff) ? q_r : k_eff;
          state_nxt = S_INS_RD;
        end
      end

      // Read the neighbor below the insertion slot, or place at the bottom
      S_INS_RD: begin
        if (r_r == '0) begin
          row_we = 1'b1;
          q_nxt  = q_r + PW'(1);
          if (q_nxt == n_eff) begin
            state_nxt = S_CORE_RD;
          end else begin
            pb_nxt    = PIW'(q_nxt);
            j_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = S_RD;
          end
        end else begin
          state_nxt = S_INS;
        end
      end

      // Shift a larger entry up, or place the new distance
      S_INS: begin
        if (row_rd > v_r) begin
          row_we    = (r_r < k_eff);
          row_wdata = row_rd;
          r_nxt     = r_m1;
          state_nxt = S_INS_RD;
        end else begin
          row_we = (r_r < k_eff);
          q_nxt  = q_r + PW'(1);
          if (q_nxt == n_eff) begin
            state_nxt = S_CORE_RD;
          end else begin
            pb_nxt    = PIW'(q_nxt);
            j_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = S_RD;
          end
        end
      end

      // Read the k-th smallest of the row
      S_CORE_RD: begin
        row_raddr = k_m1[PIW-1:0];
        state_nxt = S_CORE_WR;
      end

      // Store the core distance and advance to the next point
      S_CORE_WR: begin
        core_we = 1'b1;
        p_nxt   = p_r + PW'(1);
        if (p_nxt == n_eff) begin
          cores_valid_nxt = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          q_nxt     = '0;
          pa_nxt    = PIW'(p_nxt);
          pb_nxt    = '0;
          j_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_RD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ sv/mrd_checker.sv @@
// Port-level checker for the mutual reachability block, with its bind.
module mrd_checker
  import mrd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_status,
  input logic [OUT_W-1:0] out_mutual_reach_sq,
  input logic [OUT_W-1:0] out_core_first_sq,
  input logic [OUT_W-1:0] out_core_second_sq
);

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // One request at a time: no new request right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while one is in progress");

  // Early query answers carry no distances
  a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_NO_CORE) |->
      (out_mutual_reach_sq == '0) && (out_core_first_sq == '0) &&
      (out_core_second_sq == '0))
    else $error("status result carries nonzero distances");

  // Mutual reachability dominates both core distances
  a_reach_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_OK) |->
      (out_mutual_reach_sq >= out_core_first_sq) &&
      (out_mutual_reach_sq >= out_core_second_sq))
    else $error("mutual reachability below a core distance");

endmodule

bind mutual_reachability_distance mrd_checker u_mrd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_mutual_reach_sq (out_mutual_reach_sq),
  .out_core_first_sq   (out_core_first_sq),
  .out_core_second_sq  (out_core_second_sq)
);
